// ===== src/fdep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdep_pkg
// Shared types and constants for the FAT12 root directory entry parser.
// ----------------------------------------------------------------------------
package fdep_pkg;

	localparam int ENTRY_BYTES = 32;
	localparam int POS_W       = $clog2(ENTRY_BYTES);
	localparam int COUNT_W     = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [POS_W-1:0]   POS_FIRST   = '0;
	localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(ENTRY_BYTES - 1);
	localparam logic [7:0]         MARK_END    = 8'h00;
	localparam logic [7:0]         MARK_DELETED = 8'hE5;
	localparam logic [7:0]         CHAR_SPACE  = 8'h20;
	localparam logic [11:0]        YEAR_BASE   = 12'd1980;
	localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 16'd224;

	// Byte offsets inside one directory entry.
	localparam logic [POS_W-1:0] OFS_EXT       = 5'd8;
	localparam logic [POS_W-1:0] OFS_ATTR      = 5'd11;
	localparam logic [POS_W-1:0] OFS_TIME_LO   = 5'd22;
	localparam logic [POS_W-1:0] OFS_TIME_HI   = 5'd23;
	localparam logic [POS_W-1:0] OFS_DATE_LO   = 5'd24;
	localparam logic [POS_W-1:0] OFS_DATE_HI   = 5'd25;
	localparam logic [POS_W-1:0] OFS_SIZE_0    = 5'd28;
	localparam logic [POS_W-1:0] OFS_SIZE_1    = 5'd29;
	localparam logic [POS_W-1:0] OFS_SIZE_2    = 5'd30;

	typedef enum logic {
		KIND_ENTRY = 1'b0,
		KIND_END   = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] dir_byte;
		logic       start_req;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] name;
		logic [23:0] extension;
		logic [3:0]  name_length;
		logic [3:0]  attributes;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [31:0] file_size;
	} result_t;

	// Raw entry record handed from the front end to the decoder.
	typedef struct packed {
		kind_t       kind;
		logic [63:0] name;
		logic [23:0] extension;
		logic [3:0]  attributes;
		logic [15:0] time_word;
		logic [15:0] date_word;
		logic [31:0] file_size;
	} record_t;

endpackage
`default_nettype wire

// ===== src/fdep_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdep_front
// Byte front end: tracks entry position and count, captures entry fields
// and emits one raw record per live entry or end marker.
// ----------------------------------------------------------------------------
module fdep_front import fdep_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire item_t              item,
	input  wire logic [COUNT_W-1:0] max_entries,
	output logic                    rec_push,
	output record_t                 rec
);

	logic [POS_W-1:0]   pos_q, pos_e, pos_n;
	logic [COUNT_W-1:0] count_q, count_e, count_n;
	logic               skip_q, skip_e, skip_n, skip_now;
	logic               stop_q, stop_e, stop_n;
	logic               live, is_end, capture;

	logic [63:0] name_q;
	logic [23:0] ext_q;
	logic [7:0]  attr_q;
	logic [15:0] time_q;
	logic [15:0] date_q;
	logic [23:0] size_q;
	logic [7:0]  b;

	assign b = item.dir_byte;

	always_comb begin
		pos_e   = item.start_req ? POS_FIRST : pos_q;
		count_e = item.start_req ? '0 : count_q;
		skip_e  = item.start_req ? 1'b0 : skip_q;
		stop_e  = item.start_req ? 1'b0 : stop_q;

		live     = !stop_e && (count_e < max_entries);
		is_end   = live && (pos_e == POS_FIRST) && (b == MARK_END);
		skip_now = (pos_e == POS_FIRST) ? (b == MARK_DELETED) : skip_e;
		capture  = live && !is_end && !skip_now;

		pos_n   = pos_e;
		count_n = count_e;
		skip_n  = skip_e;
		stop_n  = stop_e;
		if (live) begin
			pos_n = pos_e + POS_W'(1);
			if (is_end) begin
				stop_n = 1'b1;
			end else begin
				skip_n = skip_now;
				if (pos_e == POS_LAST) begin
					count_n = count_e + COUNT_W'(1);
				end
			end
		end

		rec_push = accept && (is_end || (capture && pos_e == POS_LAST));
		rec = '0;
		if (!is_end) begin
			rec.kind       = KIND_ENTRY;
			rec.name       = name_q;
			rec.extension  = ext_q;
			rec.attributes = {attr_q[5], attr_q[2:0]};
			rec.time_word  = time_q;
			rec.date_word  = date_q;
			rec.file_size  = {b, size_q};
		end else begin
			rec.kind = KIND_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			skip_q  <= 1'b0;
			stop_q  <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_n;
			count_q <= count_n;
			skip_q  <= skip_n;
			stop_q  <= stop_n;
		end
	end

	// Field stores are always written earlier in the same entry than read.
	always_ff @(posedge clk) begin
		if (accept && capture) begin
			if (pos_e < OFS_EXT) begin
				name_q <= {name_q[55:0], b};
			end else if (pos_e < OFS_ATTR) begin
				ext_q <= {ext_q[15:0], b};
			end else begin
				case (pos_e)
					OFS_ATTR:    attr_q <= b;
					OFS_TIME_LO: time_q[7:0] <= b;
					OFS_TIME_HI: time_q[15:8] <= b;
					OFS_DATE_LO: date_q[7:0] <= b;
					OFS_DATE_HI: date_q[15:8] <= b;
					OFS_SIZE_0:  size_q[7:0] <= b;
					OFS_SIZE_1:  size_q[15:8] <= b;
					OFS_SIZE_2:  size_q[23:16] <= b;
					default: ;
				endcase
			end
		end
	end

	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> accept)
		else $error("record pushed without an accepted byte");

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_push && rec.kind == KIND_END) |=> stop_q)
		else $error("end marker did not stop the scan");

	a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q && !item.start_req) |-> !rec_push)
		else $error("record pushed after the end marker");

endmodule
`default_nettype wire

// ===== src/fdep_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdep_queue
// Short register queue of raw records between the front end and the decoder.
// ----------------------------------------------------------------------------
module fdep_queue import fdep_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire record_t wdata,
	output logic         full,
	input  wire logic    pop,
	output logic         empty,
	output record_t      rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	record_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("record request dropped on a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("queue count did not follow a pop");

endmodule
`default_nettype wire

// ===== src/fdep_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdep_back
// Decoder: turns a raw record into a result and holds it in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module fdep_back import fdep_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    rec_empty,
	input  wire record_t rec,
	output logic         rec_pop,
	output logic         empty,
	input  wire logic    pop,
	output result_t      result
);

	result_t dec;
	logic    valid_q;
	result_t out_q;
	logic    load;
	logic [3:0] len;

	// Length is one past the last name byte that is not a space.
	always_comb begin
		len = '0;
		for (int i = 0; i < 8; i++) begin
			if (rec.name[63-8*i -: 8] != CHAR_SPACE) begin
				len = 4'(i + 1);
			end
		end
	end

	always_comb begin
		dec = '0;
		dec.kind = rec.kind;
		if (rec.kind == KIND_ENTRY) begin
			dec.name        = rec.name;
			dec.extension   = rec.extension;
			dec.name_length = len;
			dec.attributes  = rec.attributes;
			dec.hour        = rec.time_word[15:11];
			dec.minute      = rec.time_word[10:5];
			dec.second      = {rec.time_word[4:0], 1'b0};
			dec.year        = {5'd0, rec.date_word[15:9]} + YEAR_BASE;
			dec.month       = rec.date_word[8:5];
			dec.day         = rec.date_word[4:0];
			dec.file_size   = rec.file_size;
		end
	end

	assign load    = !rec_empty && (!valid_q || pop);
	assign rec_pop = load;
	assign empty   = !valid_q;
	assign result  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= dec;
		end
	end

endmodule
`default_nettype wire

// ===== src/fat_directory_entry_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fat_directory_entry_parser
// FAT12 root directory entry parser: cuts a byte stream into 32-byte
// entries and reports each live entry and the end marker.
//
//   channel   | handshake         | payload
//   ----------+-------------------+-----------------------------
//   input     | push / full       | item   (dir_byte, start_req)
//   result    | pop / empty       | result (decoded entry)
//   config    | cfg_valid / ready | cfg_data (max_entries)
//
// One byte is accepted per cycle; full rises only when the record queue
// between front end and decoder is full.
// A completed entry is registered first in the record queue, then in the
// decoder's output register, where it is held until popped.
// Reset clears the position, entry count and flags; max_entries resets
// to 224. A stalled result side backs up the queue, then the input.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser import fdep_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire item_t              item,
	output logic                    empty,
	input  wire logic               pop,
	output result_t                 result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data
);

	logic [COUNT_W-1:0] max_entries_q;
	logic               accept;
	logic               rec_push, rec_pop, rec_empty;
	record_t            rec_in, rec_out;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_entries_q <= cfg_data;
		end
	end

	fdep_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.max_entries (max_entries_q),
		.rec_push    (rec_push),
		.rec         (rec_in)
	);

	fdep_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.full   (full),
		.pop    (rec_pop),
		.empty  (rec_empty),
		.rdata  (rec_out)
	);

	fdep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (rec_empty),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire
